// ----- rtl/core/tse_pkg.sv -----
// package with shared types and constants of the timer slot expiry engine
`timescale 1ns / 1ps
package tse_pkg;
  localparam int unsigned SLOTS_DEF = 16;
  localparam int unsigned TIME_BITS_DEF = 32;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned TV_W = 32;

  typedef enum logic [2:0] {
    OP_TICK = 3'd0,
    OP_ARM = 3'd1,
    OP_CANCEL = 3'd2,
    OP_MODIFY = 3'd3,
    OP_SET_PER = 3'd4,
    OP_CLR_PER = 3'd5,
    OP_QUERY = 3'd6,
    OP_NONE = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    EV_EXPIRED = 2'd0,
    EV_DONE = 2'd1,
    EV_ALIVE = 2'd2,
    EV_ERR_ARMED = 2'd3
  } event_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OP_RD,
    ST_SCAN,
    ST_FIRE_RD,
    ST_FIRE_WR,
    ST_OUT
  } state_t;
endpackage

// ----- rtl/core/tse_if.sv -----
// valid/ready channel interfaces for requests and results
`timescale 1ns / 1ps
interface tse_in_if;
  logic valid;
  logic ready;
  logic [2:0] opcode;
  logic [3:0] slot;
  logic [31:0] timeout_value;
  modport source (output valid, opcode, slot, timeout_value, input ready);
  modport sink (input valid, opcode, slot, timeout_value, output ready);
endinterface

interface tse_out_if;
  logic valid;
  logic ready;
  logic [3:0] slot_out;
  logic [1:0] event_kind;
  logic alive;
  logic last;
  modport source (output valid, slot_out, event_kind, alive, last, input ready);
  modport sink (input valid, slot_out, event_kind, alive, last, output ready);
endinterface

// ----- rtl/core/tse_ram.sv -----
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module tse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/timer_slot_expiry_engine.sv -----
// top level of the timer slot expiry engine
// usage:
//   in channel carries one request: opcode, slot and timeout_value.
//   out channel returns results: slot_out, event_kind, alive and last.
//   non-tick requests other than OP_NONE give one result, loaded into
//   the output register in ST_OP_RD once it is free; OP_NONE gives none.
//   the engine then returns to idle and can take the next request.
//   a tick scans all slots through the deadline memory, one slot
//   per cycle; each firing takes one further scan pass to pick the
//   earliest due slot, then a reload write for a periodic slot and a
//   result. each expiry result is held until the following pass ends,
//   so that last can be set on the final one.
//   deadlines and periods live in two rams; armed and periodic bits are
//   flops cleared at reset together with the time counter.
//   one request is worked at a time; in.ready is low while busy.
//   a result sits in an output register until taken, and the engine
//   waits while the receiver stalls.
//   slots at or beyond SLOTS answer done with alive low.
`timescale 1ns / 1ps
module timer_slot_expiry_engine #(
  parameter int unsigned SLOTS = tse_pkg::SLOTS_DEF,
  parameter int unsigned TIME_BITS = tse_pkg::TIME_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  tse_in_if.sink in_ch,
  tse_out_if.source out_ch
);
  import tse_pkg::*;

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned NW = $clog2(MAX_RESULTS + 1);

  state_t state_r, state_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [SLOTS-1:0] armed_r, armed_nxt, per_r, per_nxt, fired_r, fired_nxt;
  logic [2:0] op_r, op_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [TIME_BITS-1:0] tv_r, tv_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic rd_vld_r, rd_vld_nxt;
  logic found_r, found_nxt;
  logic [AW-1:0] best_r, best_nxt;
  logic [TIME_BITS-1:0] best_age_r, best_age_nxt;
  logic [NW-1:0] nfire_r, nfire_nxt;
  logic ov_r, ov_nxt;
  logic [SLOT_W-1:0] os_r, os_nxt;
  logic [1:0] ok_r, ok_nxt;
  logic oa_r, oa_nxt, ol_r, ol_nxt;

  logic dl_we, rp_we;
  logic [AW-1:0] dl_waddr, ram_raddr;
  logic [TIME_BITS-1:0] dl_wdata, rp_wdata, dl_rdata, rp_rdata;

  tse_ram #(.WIDTH(TIME_BITS), .DEPTH(SLOTS)) u_dl (
    .clk(clk), .we(dl_we), .waddr(dl_waddr), .wdata(dl_wdata),
    .raddr(ram_raddr), .rdata(dl_rdata)
  );
  tse_ram #(.WIDTH(TIME_BITS), .DEPTH(SLOTS)) u_rp (
    .clk(clk), .we(rp_we), .waddr(dl_waddr), .wdata(rp_wdata),
    .raddr(ram_raddr), .rdata(rp_rdata)
  );

  logic slot_ok;
  logic [AW-1:0] sidx;
  logic [TIME_BITS-1:0] diff, age;
  logic due;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.slot_out = os_r;
  assign out_ch.event_kind = ok_r;
  assign out_ch.alive = oa_r;
  assign out_ch.last = ol_r;

  assign slot_ok = ({{(32-SLOT_W){1'b0}}, slot_r} < 32'(SLOTS));
  assign sidx = AW'(slot_r);
  assign diff = dl_rdata - now_r;
  assign age = now_r - dl_rdata;
  assign due = armed_r[rd_idx_r] && !fired_r[rd_idx_r] &&
               ((diff == '0) || diff[TIME_BITS-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      now_r <= '0;
      armed_r <= '0;
      per_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      now_r <= now_nxt;
      armed_r <= armed_nxt;
      per_r <= per_nxt;
      ov_r <= ov_nxt;
    end
    fired_r <= fired_nxt;
    op_r <= op_nxt;
    slot_r <= slot_nxt;
    tv_r <= tv_nxt;
    cnt_r <= cnt_nxt;
    rd_idx_r <= rd_idx_nxt;
    rd_vld_r <= rd_vld_nxt;
    found_r <= found_nxt;
    best_r <= best_nxt;
    best_age_r <= best_age_nxt;
    nfire_r <= nfire_nxt;
    os_r <= os_nxt;
    ok_r <= ok_nxt;
    oa_r <= oa_nxt;
    ol_r <= ol_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    now_nxt = now_r;
    armed_nxt = armed_r;
    per_nxt = per_r;
    fired_nxt = fired_r;
    op_nxt = op_r;
    slot_nxt = slot_r;
    tv_nxt = tv_r;
    cnt_nxt = cnt_r;
    rd_idx_nxt = rd_idx_r;
    rd_vld_nxt = 1'b0;
    found_nxt = found_r;
    best_nxt = best_r;
    best_age_nxt = best_age_r;
    nfire_nxt = nfire_r;
    ov_nxt = ov_r;
    os_nxt = os_r;
    ok_nxt = ok_r;
    oa_nxt = oa_r;
    ol_nxt = ol_r;
    dl_we = 1'b0;
    rp_we = 1'b0;
    dl_waddr = sidx;
    dl_wdata = now_r + tv_r;
    rp_wdata = tv_r;
    ram_raddr = sidx;

    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt = in_ch.opcode;
          slot_nxt = in_ch.slot;
          tv_nxt = TIME_BITS'(in_ch.timeout_value);
          if (opcode_t'(in_ch.opcode) == OP_TICK) begin
            now_nxt = now_r + 1'b1;
            fired_nxt = '0;
            nfire_nxt = '0;
            cnt_nxt = '0;
            found_nxt = 1'b0;
            state_nxt = ST_SCAN;
          end else if (opcode_t'(in_ch.opcode) != OP_NONE) begin
            state_nxt = ST_OP_RD;
          end
        end
      end
      ST_OP_RD: begin
        if (!ov_r) begin
          os_nxt = slot_r;
          ok_nxt = EV_DONE;
          ol_nxt = 1'b1;
          oa_nxt = 1'b0;
          ov_nxt = 1'b1;
          state_nxt = ST_IDLE;
          if (slot_ok) begin
            case (opcode_t'(op_r))
              OP_ARM: begin
                if (armed_r[sidx]) begin
                  ok_nxt = EV_ERR_ARMED;
                end else begin
                  dl_we = 1'b1;
                  rp_we = 1'b1;
                  armed_nxt[sidx] = 1'b1;
                end
              end
              OP_CANCEL: armed_nxt[sidx] = 1'b0;
              OP_MODIFY: dl_we = 1'b1;
              OP_SET_PER: per_nxt[sidx] = 1'b1;
              OP_CLR_PER: per_nxt[sidx] = 1'b0;
              default: ok_nxt = EV_ALIVE;
            endcase
            oa_nxt = armed_nxt[sidx];
          end
        end
      end
      ST_SCAN: begin
        ram_raddr = AW'(cnt_r);
        if (cnt_r < CW'(SLOTS)) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = AW'(cnt_r);
          cnt_nxt = cnt_r + 1'b1;
        end
        if (rd_vld_r && due && (!found_r || age > best_age_r)) begin
          found_nxt = 1'b1;
          best_nxt = rd_idx_r;
          best_age_nxt = age;
        end
        if (cnt_r == CW'(SLOTS) && !rd_vld_r) begin
          // release the held expiry now that it is known whether more follow
          if (nfire_r != '0) begin
            ov_nxt = 1'b1;
          end
          if (found_r && nfire_r < NW'(MAX_RESULTS)) begin
            state_nxt = ST_FIRE_RD;
          end else begin
            state_nxt = ST_IDLE;
            if (nfire_r != '0) begin
              ol_nxt = 1'b1;
            end
          end
        end
      end
      ST_FIRE_RD: begin
        ram_raddr = best_r;
        state_nxt = ST_FIRE_WR;
      end
      ST_FIRE_WR: begin
        dl_waddr = best_r;
        dl_wdata = now_r + rp_rdata;
        dl_we = per_r[best_r];
        if (!per_r[best_r]) begin
          armed_nxt[best_r] = 1'b0;
        end
        fired_nxt[best_r] = 1'b1;
        nfire_nxt = nfire_r + 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_r) begin
          // hold the expiry in the output register until the next pass ends
          os_nxt = SLOT_W'(best_r);
          ok_nxt = EV_EXPIRED;
          oa_nxt = armed_r[best_r];
          ol_nxt = 1'b0;
          cnt_nxt = '0;
          found_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
